// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by sorted_timer_queue_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define STQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define STQ_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/stq_pkg.sv =====
package stq_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  // field widths
  localparam int ID_W   = 8;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;

  // derived widths
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = $clog2(((QUEUE_DEPTH > MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS) + 1);

  // input function codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_ADDED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

  // one stored task
  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] time_ms;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/stq_ram.sv =====
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sorted_timer_queue_core.sv =====
// channel  | direction | ports                                    | handshake
// ---------+-----------+------------------------------------------+-------------------------
// input    | in        | in_func, in_task_id, in_time_ms          | in_valid / in_stall
// result   | out       | out_kind, out_expired_id, out_last       | out_valid / out_stall
//
// add: shifts each stored entry with less time than the new task up by one, from the back,
//   then writes the task; no scan when the queue is empty or full; the entry memory has a
//   single read and write port. tick: a subtract pass over every stored entry, then, per
//   expired task, a read of the back entry and its result; a NONE result if none expired
// reset clears the entry count and the control state only; memory contents are left as is
// a stalled result stays in the output register; in_stall is high while an item is at work
`include "assert_macros.svh"

module sorted_timer_queue_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [stq_pkg::ID_W-1:0]     in_task_id,
  input  logic [stq_pkg::TIME_W-1:0]   in_time_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stq_pkg::KIND_W-1:0]   out_kind,
  output logic [stq_pkg::ID_W-1:0]     out_expired_id,
  output logic                         out_last
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_ADD_SCAN  = 3'd1;
  localparam logic [2:0] ST_ADD_FIN   = 3'd2;
  localparam logic [2:0] ST_TICK_SCAN = 3'd3;
  localparam logic [2:0] ST_POP_RD    = 3'd4;
  localparam logic [2:0] ST_POP_EMIT  = 3'd5;
  localparam logic [2:0] ST_EMIT      = 3'd6;

  localparam int IDX_W = stq_pkg::IDX_W;
  localparam int CNT_W = stq_pkg::CNT_W;
  localparam int CMP_W = stq_pkg::CMP_W;

  logic [2:0]                      state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [IDX_W-1:0]                pidx_r, pidx_nxt;
  logic [CNT_W-1:0]                zc_r, zc_nxt;
  logic [CNT_W-1:0]                pops_r, pops_nxt;
  logic [stq_pkg::KIND_W-1:0]      res_kind_r, res_kind_nxt;
  logic [stq_pkg::ID_W-1:0]        item_id_r, item_id_nxt;
  logic [stq_pkg::TIME_W-1:0]      item_t_r, item_t_nxt;

  logic                            out_valid_r;
  logic [stq_pkg::KIND_W-1:0]      out_kind_r;
  logic [stq_pkg::ID_W-1:0]        out_id_r;
  logic                            out_last_r;

  logic                            out_load;
  logic [stq_pkg::KIND_W-1:0]      load_kind;
  logic [stq_pkg::ID_W-1:0]        load_id;
  logic                            load_last;
  logic                            out_free;
  logic                            accept;

  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  stq_pkg::entry_t                 wr_data;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  stq_pkg::entry_t                 rd_data;

  logic [stq_pkg::TIME_W-1:0]      new_time;
  logic [CNT_W-1:0]                zc_sum;
  logic [CNT_W-1:0]                pops_cap;

  // entry memory
  stq_ram #(
    .WIDTH (stq_pkg::ENTRY_W),
    .DEPTH (stq_pkg::QUEUE_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // saturating subtract and expiry count for the tick pass
  assign new_time = (rd_data.time_ms > item_t_r) ? (rd_data.time_ms - item_t_r) : '0;
  assign zc_sum   = zc_r + ((new_time == '0) ? CNT_W'(1) : CNT_W'(0));
  assign pops_cap = (CMP_W'(zc_sum) > CMP_W'(stq_pkg::MAX_RESULTS)) ?
                    CNT_W'(stq_pkg::MAX_RESULTS) : zc_sum;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pidx_nxt     = pidx_r;
    zc_nxt       = zc_r;
    pops_nxt     = pops_r;
    res_kind_nxt = res_kind_r;
    item_id_nxt  = item_id_r;
    item_t_nxt   = item_t_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    out_load     = 1'b0;
    load_kind    = stq_pkg::KIND_ADDED;
    load_id      = '0;
    load_last    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_id_nxt = in_task_id;
          item_t_nxt  = in_time_ms;
          if (in_func == stq_pkg::FUNC_ADD) begin
            if (count_r == CNT_W'(stq_pkg::QUEUE_DEPTH)) begin
              res_kind_nxt = stq_pkg::KIND_REJECTED;
              state_nxt    = ST_EMIT;
            end else if (count_r == '0) begin
              wr_en           = 1'b1;
              wr_addr         = '0;
              wr_data.task_id = in_task_id;
              wr_data.time_ms = in_time_ms;
              count_nxt       = count_r + CNT_W'(1);
              res_kind_nxt    = stq_pkg::KIND_ADDED;
              state_nxt       = ST_EMIT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(count_r - CNT_W'(1));
              pidx_nxt  = IDX_W'(count_r - CNT_W'(1));
              state_nxt = ST_ADD_SCAN;
            end
          end else begin
            zc_nxt = '0;
            if (count_r == '0) begin
              res_kind_nxt = stq_pkg::KIND_NONE;
              state_nxt    = ST_EMIT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(count_r - CNT_W'(1));
              pidx_nxt  = IDX_W'(count_r - CNT_W'(1));
              state_nxt = ST_TICK_SCAN;
            end
          end
        end
      end
      // shift entries with less time up by one, from the back
      ST_ADD_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = pidx_r + IDX_W'(1);
        if (rd_data.time_ms < item_t_r) begin
          wr_data = rd_data;
          if (pidx_r == '0) begin
            state_nxt = ST_ADD_FIN;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = pidx_r - IDX_W'(1);
            pidx_nxt = pidx_r - IDX_W'(1);
          end
        end else begin
          wr_data.task_id = item_id_r;
          wr_data.time_ms = item_t_r;
          count_nxt       = count_r + CNT_W'(1);
          res_kind_nxt    = stq_pkg::KIND_ADDED;
          state_nxt       = ST_EMIT;
        end
      end
      // new task goes to the front
      ST_ADD_FIN: begin
        wr_en           = 1'b1;
        wr_addr         = '0;
        wr_data.task_id = item_id_r;
        wr_data.time_ms = item_t_r;
        count_nxt       = count_r + CNT_W'(1);
        res_kind_nxt    = stq_pkg::KIND_ADDED;
        state_nxt       = ST_EMIT;
      end
      // subtract elapsed time from each entry, count the expired ones
      ST_TICK_SCAN: begin
        wr_en           = 1'b1;
        wr_addr         = pidx_r;
        wr_data.task_id = rd_data.task_id;
        wr_data.time_ms = new_time;
        zc_nxt          = zc_sum;
        if (pidx_r == '0) begin
          pops_nxt = pops_cap;
          if (pops_cap == '0) begin
            res_kind_nxt = stq_pkg::KIND_NONE;
            state_nxt    = ST_EMIT;
          end else begin
            state_nxt = ST_POP_RD;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = pidx_r - IDX_W'(1);
          pidx_nxt = pidx_r - IDX_W'(1);
        end
      end
      ST_POP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = IDX_W'(count_r - CNT_W'(1));
        state_nxt = ST_POP_EMIT;
      end
      // report the back entry and drop it
      ST_POP_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = stq_pkg::KIND_EXPIRED;
          load_id   = rd_data.task_id;
          load_last = (pops_r == CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
          pops_nxt  = pops_r - CNT_W'(1);
          state_nxt = (pops_r == CNT_W'(1)) ? ST_IDLE : ST_POP_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = res_kind_r;
          load_id   = '0;
          load_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    zc_r       <= zc_nxt;
    pops_r     <= pops_nxt;
    res_kind_r <= res_kind_nxt;
    item_id_r  <= item_id_nxt;
    item_t_r   <= item_t_nxt;
    if (out_load) begin
      out_kind_r <= load_kind;
      out_id_r   <= load_id;
      out_last_r <= load_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

  // checks
  `STQ_NEVER(a_count_range, clk, rst_n, count_r > CNT_W'(stq_pkg::QUEUE_DEPTH), "entry count above depth")
  `STQ_ASSERT(a_scan_in_range, clk, rst_n, (state_r == ST_ADD_SCAN || state_r == ST_TICK_SCAN) |-> (CNT_W'(pidx_r) < count_r), "scan index past filled entries")
  `STQ_NEVER(a_pop_empty, clk, rst_n, (state_r == ST_POP_EMIT || state_r == ST_POP_RD) && (count_r == '0 || pops_r == '0), "pop with nothing left")

endmodule
